@@ hdl/cfrc_pkg.sv @@
// Shared types and constants of the CAN frame capture ring.
package cfrc_pkg;

	localparam int RING_DEPTH = 256;
	localparam int MAX_REPLY  = 32;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int SPAN_W     = $clog2(RING_DEPTH + 1);
	localparam int CNT_W      = $clog2(MAX_REPLY + 1);

	localparam logic [1:0] KIND_CAPTURE = 2'd0;
	localparam logic [1:0] KIND_READ    = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_ID     = 2'd1;
	localparam logic [1:0] CFG_MASK   = 2'd2;

	localparam logic [3:0] LEN_CAP = 4'd8;

	typedef enum logic [1:0] {
		OP_CAPTURE = 2'd0,
		OP_READ    = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [28:0] ident;
		logic        rtr;
		logic        ext;
		logic [3:0]  len;
		logic [63:0] data;
	} entry_t;

	typedef struct packed {
		op_t         op;
		entry_t      ent;
		logic [31:0] since;
	} cmd_t;

	typedef struct packed {
		logic capture_on;
		logic clear_head;
	} ctl_t;

endpackage

@@ hdl/cfrc_front.sv @@
// Front end: configuration registers, acceptance filter and command classification.
module cfrc_front import cfrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] time_ms,
	input  logic [28:0] frame_id,
	input  logic        is_extended,
	input  logic        is_remote,
	input  logic [3:0]  length_code,
	input  logic [63:0] payload,
	input  logic [31:0] since_seq,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [28:0] cfg_data,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd,
	output ctl_t        ctl
);

	logic        enable_q;
	logic [28:0] accept_id_q;
	logic [28:0] accept_mask_q;
	logic        pass;
	logic        keep;
	logic [3:0]  clamp_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			accept_id_q   <= '0;
			accept_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: enable_q      <= cfg_data[0];
				CFG_ID:     accept_id_q   <= cfg_data;
				CFG_MASK:   accept_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Switching capture off restarts the sequence numbering.
	assign ctl.capture_on = enable_q;
	assign ctl.clear_head = cfg_we && (cfg_index == CFG_ENABLE) && enable_q && !cfg_data[0];

	assign pass      = ((frame_id ^ accept_id_q) & accept_mask_q) == '0;
	assign clamp_len = (length_code > LEN_CAP) ? LEN_CAP : length_code;

	always_comb begin
		q_cmd.ent.stamp = time_ms;
		q_cmd.ent.ident = frame_id;
		q_cmd.ent.rtr   = is_remote;
		q_cmd.ent.ext   = is_extended;
		q_cmd.ent.len   = clamp_len;
		q_cmd.ent.data  = payload;
		q_cmd.since     = since_seq;
		case (kind)
			KIND_CAPTURE: begin
				q_cmd.op = OP_CAPTURE;
				keep     = enable_q && pass;
			end
			KIND_READ: begin
				q_cmd.op = OP_READ;
				keep     = 1'b1;
			end
			KIND_CLEAR: begin
				q_cmd.op = OP_CLEAR;
				keep     = 1'b1;
			end
			default: begin
				q_cmd.op = OP_CLEAR;
				keep     = 1'b0;
			end
		endcase
	end

	assign full   = q_full;
	assign q_push = push && !q_full && keep;

endmodule

@@ hdl/cfrc_queue.sv @@
// Two-entry command queue between the front end and the back end.
module cfrc_queue import cfrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output logic q_empty,
	output cmd_t rd_cmd
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign q_full  = fill_q == 2'd2;
	assign q_empty = fill_q == 2'd0;
	assign rd_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/cfrc_back.sv @@
// Back end: frame ring storage, sequence counter and read reply sequencer.
module cfrc_back import cfrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic        is_header,
	output logic [31:0] seq_value,
	output logic [31:0] lost_count,
	output logic        capture_on,
	output logic [31:0] stamp_ms,
	output logic [28:0] stored_id,
	output logic        stored_ext,
	output logic        stored_rtr,
	output logic [3:0]  stored_len,
	output logic [63:0] stored_data,
	output logic        last
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_WIN1 = 7'b0000010,
		S_WIN2 = 7'b0000100,
		S_WIN3 = 7'b0001000,
		S_HDR  = 7'b0010000,
		S_RD   = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	entry_t ring_q [RING_DEPTH];

	state_t            state_q;
	logic [31:0]       head_q;
	logic [AW-1:0]     wslot_q;
	logic [AW-1:0]     rslot_q;
	logic [31:0]       h_q;
	logic [31:0]       since_q;
	logic [31:0]       oldest_q;
	logic [31:0]       lost_q;
	logic [SPAN_W-1:0] span_q;
	logic [CNT_W-1:0]  cnt_q;
	entry_t            rd_q;
	logic              out_valid_q;
	logic              out_free;
	logic              emit;
	logic [31:0]       since_clip;
	logic              do_write;

	assign out_free   = !out_valid_q || pop;
	assign emit       = ((state_q == S_HDR) || (state_q == S_EMIT)) && out_free;
	assign empty      = !out_valid_q;
	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign do_write   = q_pop && (q_cmd.op == OP_CAPTURE);
	assign since_clip = (since_q > h_q) ? h_q : since_q;

	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_q[wslot_q] <= q_cmd.ent;
		end
		if (state_q == S_RD) begin
			rd_q <= ring_q[rslot_q];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				h_q      <= head_q;
				since_q  <= q_cmd.since;
				oldest_q <= (head_q > 32'(RING_DEPTH)) ? head_q - 32'(RING_DEPTH) : '0;
			end
			S_WIN1: begin
				if (since_q < oldest_q) begin
					lost_q  <= oldest_q - since_q;
					since_q <= oldest_q;
				end else begin
					lost_q <= '0;
				end
			end
			S_WIN2: begin
				since_q <= since_clip;
				span_q  <= SPAN_W'(h_q - since_clip);
			end
			S_WIN3: begin
				if (32'(span_q) > 32'(MAX_REPLY)) begin
					lost_q  <= lost_q + (32'(span_q) - 32'(MAX_REPLY));
					since_q <= h_q - 32'(MAX_REPLY);
					cnt_q   <= CNT_W'(MAX_REPLY);
				end else begin
					cnt_q <= CNT_W'(span_q);
				end
			end
			S_HDR: begin
				// Slot of the first frame sent, counted back from the write slot.
				if ({1'b0, wslot_q} >= (AW+1)'(cnt_q)) begin
					rslot_q <= AW'({1'b0, wslot_q} - (AW+1)'(cnt_q));
				end else begin
					rslot_q <= AW'({1'b0, wslot_q} + (AW+1)'(RING_DEPTH) - (AW+1)'(cnt_q));
				end
			end
			S_EMIT: begin
				if (out_free) begin
					since_q <= since_q + 32'd1;
					cnt_q   <= cnt_q - CNT_W'(1);
					rslot_q <= (rslot_q == AW'(RING_DEPTH - 1)) ? '0 : rslot_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			wslot_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.clear_head) begin
				head_q  <= '0;
				wslot_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_cmd.op)
							OP_CAPTURE: begin
								head_q  <= head_q + 32'd1;
								wslot_q <= (wslot_q == AW'(RING_DEPTH - 1)) ? '0 : wslot_q + AW'(1);
							end
							OP_READ: state_q <= S_WIN1;
							OP_CLEAR: begin
								head_q  <= '0;
								wslot_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_WIN1: state_q <= S_WIN2;
				S_WIN2: state_q <= S_WIN3;
				S_WIN3: state_q <= S_HDR;
				S_HDR: begin
					if (out_free) begin
						state_q <= (cnt_q == '0) ? S_IDLE : S_RD;
					end
				end
				S_RD: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= (cnt_q == CNT_W'(1)) ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_HDR) && out_free) begin
			is_header   <= 1'b1;
			seq_value   <= h_q;
			lost_count  <= lost_q;
			capture_on  <= ctl.capture_on;
			stamp_ms    <= '0;
			stored_id   <= '0;
			stored_ext  <= 1'b0;
			stored_rtr  <= 1'b0;
			stored_len  <= '0;
			stored_data <= '0;
			last        <= cnt_q == '0;
		end else if ((state_q == S_EMIT) && out_free) begin
			is_header   <= 1'b0;
			seq_value   <= since_q;
			lost_count  <= '0;
			capture_on  <= 1'b0;
			stamp_ms    <= rd_q.stamp;
			stored_id   <= rd_q.ident;
			stored_ext  <= rd_q.ext;
			stored_rtr  <= rd_q.rtr;
			stored_len  <= rd_q.len;
			stored_data <= rd_q.data;
			last        <= cnt_q == CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(seq_value) && $stable(is_header))
		else $error("waiting result was overwritten");

	a_frames_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_EMIT) |-> cnt_q != '0)
		else $error("frame walk with no frames left");

	a_head_advance: assert property (@(posedge clk) disable iff (!arst_n)
		do_write && !ctl.clear_head |=> head_q == $past(head_q) + 32'd1)
		else $error("capture did not advance the head");

	a_span_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WIN3 |-> 32'(span_q) <= 32'(RING_DEPTH))
		else $error("read window wider than the ring");

	a_window_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WIN3 |-> since_q <= h_q)
		else $error("window start beyond head");
`endif

endmodule

@@ hdl/can_frame_capture_ring_core.sv @@
// Top level of the CAN frame capture ring: front end, command queue and back end.
// The block takes commands through a queue-style port (push/full) and returns result
// beats through a queue-style port (empty/pop). A capture command (kind 0) is checked
// against capture_enable and the acceptance filter, where the frame is taken when
// (frame_id AND accept_mask) equals (accept_id AND accept_mask), and a taken frame is
// stored in a 256-slot ring at the current head sequence number, with its length code
// clamped to 8; captures and clears (kind 2) give no beats, and kind 3 is dropped.
// A read command (kind 1) gives a header beat (head sequence, lost count, enable) and
// then up to 32 frame beats, oldest first, with last marking the final beat. Timing:
// the front end classifies in the cycle of acceptance and hands the command to a
// two-entry queue; the back end handles a capture or clear in S_IDLE, and for a read
// works out the window in S_WIN1 to S_WIN3, sends the header from S_HDR and takes
// each frame through S_RD and S_EMIT, since each frame is a registered read of the
// single-port ring memory; the header and each frame wait while the consumer holds
// pop low. Commands keep entering while the queue has room. Writing 0 to
// capture_enable while capture is on restarts the sequence numbering, as does a clear.
// Ring slots not written since the last restart are never read. Configuration may only
// be written while the block is idle. There is no clearing pass after reset.
module can_frame_capture_ring_core import cfrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] time_ms,
	input  logic [28:0] frame_id,
	input  logic        is_extended,
	input  logic        is_remote,
	input  logic [3:0]  length_code,
	input  logic [63:0] payload,
	input  logic [31:0] since_seq,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [28:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic        is_header,
	output logic [31:0] seq_value,
	output logic [31:0] lost_count,
	output logic        capture_on,
	output logic [31:0] stamp_ms,
	output logic [28:0] stored_id,
	output logic        stored_ext,
	output logic        stored_rtr,
	output logic [3:0]  stored_len,
	output logic [63:0] stored_data,
	output logic        last
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head_cmd;
	ctl_t ctl;

	// Filtering and configuration live in the front end.
	cfrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.time_ms     (time_ms),
		.frame_id    (frame_id),
		.is_extended (is_extended),
		.is_remote   (is_remote),
		.length_code (length_code),
		.payload     (payload),
		.since_seq   (since_seq),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd),
		.ctl         (ctl)
	);

	// The queue lets the front end keep accepting while a reply is walked out.
	cfrc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_cmd  (push_cmd),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_cmd  (head_cmd)
	);

	// The back end owns the ring, the head counter and the output register.
	cfrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.q_empty     (q_empty),
		.q_cmd       (head_cmd),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.is_header   (is_header),
		.seq_value   (seq_value),
		.lost_count  (lost_count),
		.capture_on  (capture_on),
		.stamp_ms    (stamp_ms),
		.stored_id   (stored_id),
		.stored_ext  (stored_ext),
		.stored_rtr  (stored_rtr),
		.stored_len  (stored_len),
		.stored_data (stored_data),
		.last        (last)
	);

endmodule
